### sv/pos_pkg.sv
package pos_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [3:0] region_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [1:0] result_count_type;

   localparam region_type REGION_TOP_LEFT     = 4'd0;
   localparam region_type REGION_TOP          = 4'd1;
   localparam region_type REGION_TOP_RIGHT    = 4'd2;
   localparam region_type REGION_LEFT         = 4'd3;
   localparam region_type REGION_WINDOW       = 4'd4;
   localparam region_type REGION_RIGHT        = 4'd5;
   localparam region_type REGION_BOTTOM_LEFT  = 4'd6;
   localparam region_type REGION_BOTTOM       = 4'd7;
   localparam region_type REGION_BOTTOM_RIGHT = 4'd8;

   localparam csr_index_type CSR_WINDOW_LEFT   = 3'd0;
   localparam csr_index_type CSR_WINDOW_RIGHT  = 3'd1;
   localparam csr_index_type CSR_WINDOW_BOTTOM = 3'd2;
   localparam csr_index_type CSR_WINDOW_TOP    = 3'd3;
   localparam csr_index_type CSR_FILL_ENABLED  = 3'd4;

   localparam coord_type WINDOW_LEFT_RESET   = COORD_WIDTH'(0);
   localparam coord_type WINDOW_RIGHT_RESET  = COORD_WIDTH'(65536);
   localparam coord_type WINDOW_BOTTOM_RESET = COORD_WIDTH'(0);
   localparam coord_type WINDOW_TOP_RESET    = COORD_WIDTH'(65536);

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic      curve_end;
   } req_type;

   typedef struct packed {
      coord_type  out_x;
      coord_type  out_y;
      region_type snap_region;
      logic       snapped;
      logic       replaces_previous;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      coord_type window_left;
      coord_type window_right;
      coord_type window_bottom;
      coord_type window_top;
      logic      fill_enabled;
   } window_type;

   typedef struct packed {
      result_count_type             count;
      rsp_type [MAX_RESULTS-1:0]    results;
   } push_type;

   function automatic region_type region_of(coord_type x, coord_type y, window_type w);
      logic [1:0] col;
      logic [1:0] row;
      if (x < w.window_left) col = 2'd0;
      else if (x > w.window_right) col = 2'd2;
      else col = 2'd1;
      if (y > w.window_top) row = 2'd0;
      else if (y < w.window_bottom) row = 2'd2;
      else row = 2'd1;
      return region_type'({row, 1'b0}) + region_type'(row) + region_type'(col);
   endfunction

   function automatic logic is_diagonal_skip(region_type a, region_type b);
      return (a == REGION_LEFT   && b == REGION_TOP)    || (a == REGION_TOP    && b == REGION_LEFT)   ||
             (a == REGION_TOP    && b == REGION_RIGHT)  || (a == REGION_RIGHT  && b == REGION_TOP)    ||
             (a == REGION_RIGHT  && b == REGION_BOTTOM) || (a == REGION_BOTTOM && b == REGION_RIGHT)  ||
             (a == REGION_BOTTOM && b == REGION_LEFT)   || (a == REGION_LEFT   && b == REGION_BOTTOM);
   endfunction

endpackage

### sv/pos_cull_core.sv
module pos_cull_core import pos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req,
   input  window_type window,
   output push_type   push
);

   region_type prev_region_ff, prev_region_in;
   logic       first_ff, first_in;
   logic       prev_emitted_ff, prev_emitted_in;
   coord_type  prev_x_ff, prev_x_in;
   coord_type  prev_y_ff, prev_y_in;

   region_type cur;
   logic       take_window, moved, snap_move;
   logic       en_a, en_b, en_c;
   rsp_type    res_a, res_b, res_c;
   rsp_type    slot0, slot1, slot2;
   result_count_type count;

   always_comb begin
      cur = region_of(req.point_x, req.point_y, window);
      take_window = (cur == REGION_WINDOW) || (first_ff && window.fill_enabled);
      moved = !take_window && (cur != prev_region_ff);
      snap_move = moved && !(prev_region_ff == REGION_WINDOW ||
                             is_diagonal_skip(prev_region_ff, cur));

      en_a = 1'b0;
      res_a = '{out_x: prev_x_ff, out_y: prev_y_ff, snap_region: prev_region_ff,
                snapped: 1'b0, replaces_previous: 1'b0, last_of_run: 1'b0};
      if (take_window) begin
         en_a = !prev_emitted_ff ||
                (prev_region_ff != REGION_WINDOW && !first_ff);
         res_a.replaces_previous = prev_emitted_ff;
      end else if (moved) begin
         en_a = !prev_emitted_ff;
         if (snap_move) begin
            res_a.snap_region = cur;
            res_a.snapped = 1'b1;
         end
      end

      en_b = take_window || moved;
      res_b = '{out_x: req.point_x, out_y: req.point_y, snap_region: cur,
                snapped: snap_move, replaces_previous: 1'b0, last_of_run: 1'b0};

      en_c = req.curve_end && (cur != REGION_WINDOW) && window.fill_enabled;
      res_c = '{out_x: req.point_x, out_y: req.point_y, snap_region: cur,
                snapped: 1'b0, replaces_previous: 1'b0, last_of_run: 1'b0};

      slot0 = en_a ? res_a : (en_b ? res_b : res_c);
      slot1 = en_a ? (en_b ? res_b : res_c) : res_c;
      slot2 = res_c;
      count = result_count_type'(en_a) + result_count_type'(en_b) +
              result_count_type'(en_c);
      case (count)
         2'd1:    slot0.last_of_run = 1'b1;
         2'd2:    slot1.last_of_run = 1'b1;
         2'd3:    slot2.last_of_run = 1'b1;
         default: ;
      endcase
      push.count = count;
      push.results = {slot2, slot1, slot0};
   end

   always_comb begin
      if (req.curve_end) begin
         prev_region_in = REGION_WINDOW;
         first_in = 1'b1;
         prev_emitted_in = 1'b1;
         prev_x_in = '0;
         prev_y_in = '0;
      end else begin
         prev_region_in = cur;
         first_in = 1'b0;
         prev_emitted_in = take_window || moved;
         prev_x_in = req.point_x;
         prev_y_in = req.point_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_region_ff <= REGION_WINDOW;
         first_ff <= 1'b1;
         prev_emitted_ff <= 1'b1;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else if (accept) begin
         prev_region_ff <= prev_region_in;
         first_ff <= first_in;
         prev_emitted_ff <= prev_emitted_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
      end
   end

   a_region_range: assert property (@(posedge clock) disable iff (reset)
      prev_region_ff <= REGION_BOTTOM_RIGHT)
      else $error("previous region out of range");

   a_first_in_window: assert property (@(posedge clock) disable iff (reset)
      first_ff |-> (prev_region_ff == REGION_WINDOW && prev_emitted_ff))
      else $error("start state inconsistent");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req.curve_end) |=> first_ff)
      else $error("curve end did not return to start");

endmodule

### sv/pos_result_queue.sv
module pos_result_queue import pos_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   rsp_type    slot_ff [QUEUE_DEPTH];
   rsp_type    slot_in [QUEUE_DEPTH];
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] base;
   logic       pop;

   always_comb begin
      pop = rsp_valid && rsp_ready;
      base = cnt_ff - 3'(pop);
      room = base <= 3'd1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) slot_in[i] = slot_ff[i+1];
         else slot_in[i] = slot_ff[i];
         if (accept && 3'(i) >= base && (3'(i) - base) < {1'b0, push.count}) begin
            slot_in[i] = push.results[2'(3'(i) - base)];
         end
      end
      cnt_in = accept ? base + {1'b0, push.count} : base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_payload = slot_ff[0];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> room)
      else $error("request taken without room");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (accept && push.count != 2'd0) |=> rsp_valid)
      else $error("pushed result not presented");

endmodule

### sv/polyline_offscreen_simplifier.sv
// Sorts each request point into one of nine regions around the window held in
// the CSRs and emits zero to three kept points per request. A request is taken
// every cycle while the four-entry result queue holds at most one entry after
// this cycle's pop; results leave one per cycle, so a request with three
// results, back-to-back requests with two or more, or a stalled rsp side drop
// req_ready until the queue is back to one entry after the pop.
// Results are registered in the result queue before they are presented. CSR
// writes take effect for the next request.
module polyline_offscreen_simplifier import pos_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data
);

   window_type window_ff, window_in;
   push_type   push;
   logic       room;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_ready = room;
   assign accept = req_valid && room;

   always_comb begin
      window_in = window_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LEFT:   window_in.window_left   = csr_data;
            CSR_WINDOW_RIGHT:  window_in.window_right  = csr_data;
            CSR_WINDOW_BOTTOM: window_in.window_bottom = csr_data;
            CSR_WINDOW_TOP:    window_in.window_top    = csr_data;
            CSR_FILL_ENABLED:  window_in.fill_enabled  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.window_left   <= WINDOW_LEFT_RESET;
         window_ff.window_right  <= WINDOW_RIGHT_RESET;
         window_ff.window_bottom <= WINDOW_BOTTOM_RESET;
         window_ff.window_top    <= WINDOW_TOP_RESET;
         window_ff.fill_enabled  <= 1'b0;
      end else begin
         window_ff <= window_in;
      end
   end

   pos_cull_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .window (window_ff),
      .push   (push)
   );

   pos_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
